// ----- sv/epw_pkg.sv -----
// ----------------------------------------------------------------------------
// epw_pkg
// Shared types and codes for the e-paper waveform row encoder.
// ----------------------------------------------------------------------------
package epw_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam logic [1:0] MODE_MONO    = 2'd0;
    localparam logic [1:0] MODE_PARTIAL = 2'd1;
    localparam logic [1:0] MODE_GRAY    = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic KIND_TABLE = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // second-stage operations
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_EMIT  = 2'd1;
    localparam logic [1:0] OP_STORE = 2'd2;
    localparam logic [1:0] OP_GRAY  = 2'd3;

    localparam logic [1:0] LAST_LANE = 2'd3;

    localparam logic [7:0] LO_NIBBLE = 8'h0F;
    localparam logic [7:0] HI_NIBBLE = 8'hF0;

    typedef struct packed {
        logic       kind;
        logic [7:0] table_index;
        logic [7:0] table_value;
        logic       row_start;
        logic [7:0] new_byte;
        logic [7:0] old_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       group_last;
    } out_item_t;

endpackage

// ----- sv/epw_table_ram.sv -----
// ----------------------------------------------------------------------------
// epw_table_ram
// Waveform table: one write port, two registered read ports. Addresses at or
// above DEPTH are dropped on write and read back as zero.
// ----------------------------------------------------------------------------
module epw_table_ram
    import epw_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       we,
    input  logic [7:0] waddr,
    input  logic [7:0] wdata,
    input  logic [7:0] raddr_a,
    input  logic [7:0] raddr_b,
    output logic [7:0] rdata_a,
    output logic [7:0] rdata_b
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [8:0] DEPTH_W = 9'(DEPTH);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_a_reg;
    logic [7:0] rd_b_reg;
    logic       oob_a_reg;
    logic       oob_b_reg;

    always_ff @(posedge clk)
    begin
        if (we && ({1'b0, waddr} < DEPTH_W))
        begin
            mem[waddr[AW-1:0]] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg  <= mem[raddr_a[AW-1:0]];
        rd_b_reg  <= mem[raddr_b[AW-1:0]];
        oob_a_reg <= ({1'b0, raddr_a} >= DEPTH_W);
        oob_b_reg <= ({1'b0, raddr_b} >= DEPTH_W);
    end

    assign rdata_a = oob_a_reg ? 8'd0 : rd_a_reg;
    assign rdata_b = oob_b_reg ? 8'd0 : rd_b_reg;

endmodule

// ----- sv/epaper_waveform_row_encoder.sv -----
// ----------------------------------------------------------------------------
// epaper_waveform_row_encoder
// Encodes framebuffer bytes into panel bus bytes through a waveform table.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/stall channel. kind 0 requests write the waveform table,
//           kind 1 requests carry a framebuffer byte (rows arrive end first).
//   out_* : valid/stall channel of wire bytes; group_last marks the 4th byte.
//   cfg_* : valid/ready write of encode_mode; always ready. Writing it
//           restarts byte grouping. Write it only while the block is idle.
// Path: a byte that completes a group goes through the registered table read
//   into the output queue, which sends one wire byte per cycle while
//   out_stall is low. In mono/partial mode two input requests make four wire
//   bytes; the four lookups of a request are served in the same cycle by two
//   dual-read copies of the table. Requests that emit nothing go at one per
//   cycle while the output queue has room.
// Stall: the output queue holds two groups; in_stall rises while less than
//   one free group remains, counting a group still in the lookup stage.
// Reset: grouping, mode and queue clear; table contents stay undefined
//   until written.
// ----------------------------------------------------------------------------
module epaper_waveform_row_encoder
    import epw_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_data
);

    logic [1:0] mode_reg;
    logic [2:0] pos_reg,      pos_next;
    logic [7:0] held_new_reg, held_new_next;
    logic [7:0] held_old_reg, held_old_next;
    logic [1:0] op_reg,       op_next;
    logic [1:0] sidx_reg,     sidx_next;
    logic [7:0] cc_reg [3];
    logic [7:0] q_reg [2][4];
    logic       wp_reg;
    logic [2:0] rp_reg;
    logic [3:0] cnt_reg,      cnt_next;

    logic       acc;
    logic       byte_acc;
    logic       tbl_we;
    logic [2:0] pos_eff;
    logic [7:0] addr [4];
    logic [7:0] rd [4];
    logic [7:0] comb_c;
    logic       push;
    logic       pop;
    logic [4:0] occ;

    assign cfg_ready = 1'b1;
    assign acc       = in_valid & ~in_stall;
    assign tbl_we    = acc & (in_data.kind == KIND_TABLE);
    assign byte_acc  = acc & (in_data.kind == KIND_PIXEL) & (mode_reg != MODE_UNUSED);
    assign pos_eff   = in_data.row_start ? 3'd0 : pos_reg;

    always_comb
    begin
        pos_next      = pos_reg;
        held_new_next = held_new_reg;
        held_old_next = held_old_reg;
        op_next       = OP_NONE;
        sidx_next     = pos_eff[2:1];
        addr[0]       = {4'd0, in_data.new_byte[7:4]};
        addr[1]       = in_data.new_byte & LO_NIBBLE;
        addr[2]       = {4'd0, held_new_reg[7:4]};
        addr[3]       = held_new_reg & LO_NIBBLE;
        unique case (mode_reg)
            MODE_MONO, MODE_PARTIAL:
            begin
                if (mode_reg == MODE_PARTIAL)
                begin
                    addr[0] = (in_data.old_byte & HI_NIBBLE) | {4'd0, in_data.new_byte[7:4]};
                    addr[1] = {in_data.old_byte[3:0], in_data.new_byte[3:0]};
                    addr[2] = (held_old_reg & HI_NIBBLE) | {4'd0, held_new_reg[7:4]};
                    addr[3] = {held_old_reg[3:0], held_new_reg[3:0]};
                end
                if (byte_acc)
                begin
                    if (pos_eff == 3'd0)
                    begin
                        held_new_next = in_data.new_byte;
                        held_old_next = in_data.old_byte;
                        pos_next      = 3'd1;
                    end
                    else
                    begin
                        pos_next = 3'd0;
                        op_next  = OP_EMIT;
                    end
                end
            end
            MODE_GRAY:
            begin
                addr[0] = {4'd0, held_new_reg[7:4]};
                addr[1] = held_new_reg & LO_NIBBLE;
                addr[2] = {4'd0, in_data.new_byte[7:4]};
                addr[3] = in_data.new_byte & LO_NIBBLE;
                if (byte_acc)
                begin
                    if (!pos_eff[0])
                    begin
                        held_new_next = in_data.new_byte;
                        pos_next      = pos_eff + 3'd1;
                    end
                    else if (pos_eff != 3'd7)
                    begin
                        pos_next = pos_eff + 3'd1;
                        op_next  = OP_STORE;
                    end
                    else
                    begin
                        pos_next = 3'd0;
                        op_next  = OP_GRAY;
                    end
                end
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    epw_table_ram #(.DEPTH(TABLE_DEPTH)) u_ram_lo (
        .clk     (clk),
        .we      (tbl_we),
        .waddr   (in_data.table_index),
        .wdata   (in_data.table_value),
        .raddr_a (addr[0]),
        .raddr_b (addr[1]),
        .rdata_a (rd[0]),
        .rdata_b (rd[1])
    );

    epw_table_ram #(.DEPTH(TABLE_DEPTH)) u_ram_hi (
        .clk     (clk),
        .we      (tbl_we),
        .waddr   (in_data.table_index),
        .wdata   (in_data.table_value),
        .raddr_a (addr[2]),
        .raddr_b (addr[3]),
        .rdata_a (rd[2]),
        .rdata_b (rd[3])
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_MONO;
            pos_reg      <= 3'd0;
            held_new_reg <= 8'd0;
            held_old_reg <= 8'd0;
            op_reg       <= OP_NONE;
        end
        else
        begin
            op_reg       <= op_next;
            held_new_reg <= held_new_next;
            held_old_reg <= held_old_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
                pos_reg  <= 3'd0;
            end
            else
            begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sidx_reg <= sidx_next;
    end

    // gray combine, truncated to a byte
    assign comb_c = {rd[0][1:0], 6'd0} | {rd[1][3:0], 4'd0} | {rd[2][5:0], 2'd0} | rd[3];

    assign push = (op_reg == OP_EMIT) || (op_reg == OP_GRAY);

    always_ff @(posedge clk)
    begin
        if (op_reg == OP_STORE)
        begin
            cc_reg[sidx_reg] <= comb_c;
        end
        if (op_reg == OP_EMIT)
        begin
            q_reg[wp_reg][0] <= rd[0];
            q_reg[wp_reg][1] <= rd[1];
            q_reg[wp_reg][2] <= rd[2];
            q_reg[wp_reg][3] <= rd[3];
        end
        else if (op_reg == OP_GRAY)
        begin
            q_reg[wp_reg][0] <= cc_reg[2];
            q_reg[wp_reg][1] <= comb_c;
            q_reg[wp_reg][2] <= cc_reg[0];
            q_reg[wp_reg][3] <= cc_reg[1];
        end
    end

    assign out_valid           = (cnt_reg != 4'd0);
    assign pop                 = out_valid & ~out_stall;
    assign out_data.wire_byte  = q_reg[rp_reg[2]][rp_reg[1:0]];
    assign out_data.group_last = (rp_reg[1:0] == LAST_LANE);

    assign occ      = {1'b0, cnt_reg} + (push ? 5'd4 : 5'd0);
    assign in_stall = (occ > 5'd4);
    assign cnt_next = cnt_reg + (push ? 4'd4 : 4'd0) - (pop ? 4'd1 : 4'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 3'd0;
            cnt_reg <= 4'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 3'd1;
            end
        end
    end

endmodule

// ----- sv/epw_checker.sv -----
// ----------------------------------------------------------------------------
// epw_checker
// Port-level checks for the e-paper waveform row encoder.
// ----------------------------------------------------------------------------
module epw_checker
    import epw_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input out_item_t  out_data,
    input logic       cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    a_group_runs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.group_last |=> out_valid)
        else $error("group broken off before its last byte");

    a_empty_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output queue");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind epaper_waveform_row_encoder epw_checker u_epw_checker (.*);
